// ----- rtl/xy_stepper_move_generator_unit_assert.svh -----
// assertion macros for the step generator
`ifndef XY_STEPPER_MOVE_GENERATOR_UNIT_ASSERT_SVH
`define XY_STEPPER_MOVE_GENERATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define XYSM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define XYSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define XYSM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define XYSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/xysm_pkg.sv -----
package xysm_pkg;

   localparam int MAG_W = 16;
   localparam int ACC_W = 72;
   localparam int OPB_W = 40;
   localparam int CSR_DATA_W = 20;

   localparam logic [5:0] MUL_STEPS = 6'd40;
   localparam logic [5:0] DIV_STEPS = 6'd40;
   localparam logic [5:0] SQRT_STEPS = 6'd36;

   localparam logic [19:0] RESET_MIN_STEP_PERIOD = 20'd1000;
   localparam logic [14:0] RESET_LIMIT = 15'd1000;

   typedef enum logic [1:0] {
      CMD_MOVE,
      CMD_TICK,
      CMD_IDLE,
      CMD_NOP
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_MIN_STEP_PERIOD,
      CSR_LIMIT_X,
      CSR_LIMIT_Y,
      CSR_BACKLASH_X,
      CSR_BACKLASH_Y
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_NONE,
      PH_BACKLASH,
      PH_MAIN
   } phase_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_PP,
      ST_PRS,
      ST_ROOT,
      ST_BASE,
      ST_MQ,
      ST_DIVX,
      ST_DIVY
   } seq_state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [14:0] target_x;
      logic [14:0] target_y;
   } req_type;

   typedef struct packed {
      logic x_step;
      logic x_motor_forward;
      logic y_step;
      logic y_motor_forward;
      logic busy_res;
      logic move_rejected;
      logic motors_idle;
   } rsp_type;

endpackage

// ----- rtl/xysm_serial_unit.sv -----
module xysm_serial_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  xysm_pkg::alu_op_type      op,
   input  logic [xysm_pkg::ACC_W-1:0] opa,
   input  logic [xysm_pkg::OPB_W-1:0] opb,
   input  logic [xysm_pkg::ACC_W-1:0] opc,
   output logic [xysm_pkg::ACC_W-1:0] result,
   output logic                      done
);

   logic                       busy_ff;
   logic                       done_ff;
   xysm_pkg::alu_op_type       op_ff;
   logic [5:0]                 cnt_ff;
   logic [xysm_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [xysm_pkg::ACC_W-1:0] sh_ff, sh_in;
   logic [xysm_pkg::OPB_W-1:0] aux_ff, aux_in;

   logic [xysm_pkg::ACC_W-1:0] add_a, add_b;
   logic                       sub;
   logic [xysm_pkg::ACC_W:0]   sum;
   logic                       no_borrow;

   // one shared adder, subtract mode for the restoring steps
   always_comb begin
      add_a = acc_ff;
      add_b = sh_ff;
      sub = 1'b0;
      case (op_ff)
         xysm_pkg::ALU_DIV: begin
            add_a = {31'd0, acc_ff[39:0], sh_ff[39]};
            add_b = {32'd0, aux_ff};
            sub = 1'b1;
         end
         xysm_pkg::ALU_SQRT: begin
            add_a = {32'd0, acc_ff[37:0], sh_ff[71:70]};
            add_b = {32'd0, aux_ff[37:0], 2'b01};
            sub = 1'b1;
         end
         default: begin
            add_a = acc_ff;
            add_b = sh_ff;
            sub = 1'b0;
         end
      endcase
      sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{xysm_pkg::ACC_W{1'b0}}, sub};
      no_borrow = sum[xysm_pkg::ACC_W];
   end

   always_comb begin
      acc_in = acc_ff;
      sh_in = sh_ff;
      aux_in = aux_ff;
      case (op_ff)
         xysm_pkg::ALU_DIV: begin
            acc_in = no_borrow ? sum[xysm_pkg::ACC_W-1:0] : add_a;
            sh_in = {sh_ff[70:0], no_borrow};
         end
         xysm_pkg::ALU_SQRT: begin
            acc_in = no_borrow ? sum[xysm_pkg::ACC_W-1:0] : add_a;
            sh_in = {sh_ff[69:0], 2'b00};
            aux_in = {aux_ff[38:0], no_borrow};
         end
         default: begin
            acc_in = aux_ff[0] ? sum[xysm_pkg::ACC_W-1:0] : acc_ff;
            sh_in = {sh_ff[70:0], 1'b0};
            aux_in = {1'b0, aux_ff[39:1]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         op_ff <= xysm_pkg::ALU_MUL;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            op_ff <= op;
            case (op)
               xysm_pkg::ALU_DIV: cnt_ff <= xysm_pkg::DIV_STEPS;
               xysm_pkg::ALU_SQRT: cnt_ff <= xysm_pkg::SQRT_STEPS;
               default: cnt_ff <= xysm_pkg::MUL_STEPS;
            endcase
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         sh_ff <= opa;
         case (op)
            xysm_pkg::ALU_MUL: begin
               acc_ff <= opc;
               aux_ff <= opb;
            end
            xysm_pkg::ALU_DIV: begin
               acc_ff <= '0;
               aux_ff <= opb;
            end
            default: begin
               acc_ff <= '0;
               aux_ff <= '0;
            end
         endcase
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         sh_ff <= sh_in;
         aux_ff <= aux_in;
      end
   end

   always_comb begin
      case (op_ff)
         xysm_pkg::ALU_DIV: result = {32'd0, sh_ff[39:0]};
         xysm_pkg::ALU_SQRT: result = {32'd0, aux_ff};
         default: result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

// ----- rtl/xysm_axis.sv -----
module xysm_axis #(
   parameter int PERIOD_BITS = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  logic                       load,
   input  logic [xysm_pkg::MAG_W-1:0] left_load,
   input  logic [PERIOD_BITS-1:0]     period_load,
   output logic                       step,
   output logic                       last
);

   logic [xysm_pkg::MAG_W-1:0] left_ff;
   logic [PERIOD_BITS-1:0]     period_ff;
   logic [PERIOD_BITS-1:0]     since_ff;
   logic                       due;

   assign due = since_ff >= period_ff;
   assign step = tick && (left_ff != '0) && due;
   assign last = (left_ff == '0) || (due && left_ff == xysm_pkg::MAG_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         period_ff <= '0;
         since_ff <= '0;
      end else if (load) begin
         left_ff <= left_load;
         period_ff <= period_load;
         since_ff <= period_load;
      end else if (tick && left_ff != '0) begin
         if (due) begin
            left_ff <= left_ff - xysm_pkg::MAG_W'(1);
            since_ff <= PERIOD_BITS'(1);
         end else if (since_ff != '1) begin
            since_ff <= since_ff + PERIOD_BITS'(1);
         end
      end
   end

endmodule

// ----- rtl/xy_stepper_move_generator_unit.sv -----
// channel   | direction | handshake             | payload
// req       | in        | req_valid / req_ready | req_data (cmd, target_x, target_y)
// rsp       | out       | rsp_valid / rsp_ready | rsp_data (steps, directions, flags)
// csr       | in        | csr_valid / csr_ready | csr_index, csr_data
//
// tick, idle, nop and rejected moves are answered from idle, result registered
// a move that needs steps, or a tick that ends the backlash phase with main steps left,
// then holds req_ready low while the bit-serial unit works out the phase periods
// (nine multiply, divide and root passes of 36 to 40 steps each)
// synchronous active-high reset; rsp holds its transfer until taken, req waits on it
module xy_stepper_move_generator_unit #(
   parameter int POSITION_BITS = 16,
   parameter int PERIOD_BITS = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  xysm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output xysm_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  xysm_pkg::csr_index_type         csr_index,
   input  logic [xysm_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam logic [63:0] PMAX = ((64'd1 << (PERIOD_BITS - 1)) << 1) - 64'd1;

   xysm_pkg::seq_state_type state_ff, state_in;
   logic go_ff, go_in;

   logic [19:0] min_period_ff;
   logic [14:0] limit_x_ff, limit_y_ff;
   logic [7:0]  backlash_x_ff, backlash_y_ff;

   logic [POSITION_BITS-1:0] pos_x_ff, pos_y_ff;
   logic pos_take;
   logic dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   xysm_pkg::phase_type phase_ff, phase_in;
   logic [xysm_pkg::MAG_W-1:0] main_x_ff, main_x_in, main_y_ff, main_y_in;
   logic [xysm_pkg::MAG_W-1:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [xysm_pkg::MAG_W-1:0] mag_max;

   logic [31:0] s_ff;
   logic [39:0] pp_ff;
   logic [71:0] r_ff;
   logic [35:0] root_ff;
   logic [21:0] q_ff;
   logic [39:0] mq_ff;
   logic [PERIOD_BITS-1:0] per_x_ff, per_sat;
   logic [63:0] div64;
   logic div_zero;

   logic rsp_valid_ff;
   xysm_pkg::rsp_type rsp_data_ff, rsp_in;
   logic accept;

   logic [14:0] tx, ty;
   logic in_bounds;
   logic signed [16:0] dx, dy;
   logic dx_pos, dx_neg, dy_pos, dy_neg;
   logic [xysm_pkg::MAG_W-1:0] adx, ady, bx, by;

   logic tick_en, axis_load;
   logic x_step, y_step, x_last, y_last;
   logic rej, idle;

   logic u_start, u_done;
   xysm_pkg::alu_op_type u_op;
   logic [xysm_pkg::ACC_W-1:0] u_opa, u_opc, u_result;
   logic [xysm_pkg::OPB_W-1:0] u_opb;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == xysm_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign tx = req_data.target_x;
   assign ty = req_data.target_y;
   assign in_bounds = (tx != '0) && (tx < limit_x_ff) && (ty != '0) && (ty < limit_y_ff);
   assign dx = $signed({2'b00, tx}) - $signed({1'b0, 16'(pos_x_ff)});
   assign dy = $signed({2'b00, ty}) - $signed({1'b0, 16'(pos_y_ff)});
   assign dx_neg = dx[16];
   assign dy_neg = dy[16];
   assign dx_pos = !dx[16] && (dx != '0);
   assign dy_pos = !dy[16] && (dy != '0);
   assign adx = dx_neg ? 16'(-dx) : 16'(dx);
   assign ady = dy_neg ? 16'(-dy) : 16'(dy);
   assign bx = ((dx_pos && !dir_x_ff) || (dx_neg && dir_x_ff)) ? 16'(backlash_x_ff) : '0;
   assign by = ((dy_pos && !dir_y_ff) || (dy_neg && dir_y_ff)) ? 16'(backlash_y_ff) : '0;
   assign mag_max = (mag_x_ff > mag_y_ff) ? mag_x_ff : mag_y_ff;

   // saturate the axis period, an axis with no steps gets the largest value
   assign div64 = 64'(u_result[39:0]);
   assign div_zero = (state_ff == xysm_pkg::ST_DIVX) ? (mag_x_ff == '0) : (mag_y_ff == '0);
   assign per_sat = (div_zero || div64 > PMAX) ? PERIOD_BITS'(PMAX) : PERIOD_BITS'(div64);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xysm_pkg::ST_IDLE;
         go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      go_in = 1'b0;
      phase_in = phase_ff;
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      main_x_in = main_x_ff;
      main_y_in = main_y_ff;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      pos_take = 1'b0;
      tick_en = 1'b0;
      axis_load = 1'b0;
      rej = 1'b0;
      idle = 1'b0;
      u_start = 1'b0;
      u_op = xysm_pkg::ALU_MUL;
      u_opa = '0;
      u_opb = '0;
      u_opc = '0;
      unique case (state_ff)
         xysm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  xysm_pkg::CMD_MOVE: begin
                     if (phase_ff != xysm_pkg::PH_NONE || !in_bounds) begin
                        rej = 1'b1;
                     end else begin
                        if (dx != '0) dir_x_in = dx_pos;
                        if (dy != '0) dir_y_in = dy_pos;
                        main_x_in = adx;
                        main_y_in = ady;
                        pos_take = 1'b1;
                        if (bx != '0 || by != '0) begin
                           phase_in = xysm_pkg::PH_BACKLASH;
                           mag_x_in = bx;
                           mag_y_in = by;
                           state_in = xysm_pkg::ST_SQX;
                           go_in = 1'b1;
                        end else if (adx != '0 || ady != '0) begin
                           phase_in = xysm_pkg::PH_MAIN;
                           mag_x_in = adx;
                           mag_y_in = ady;
                           state_in = xysm_pkg::ST_SQX;
                           go_in = 1'b1;
                        end else begin
                           phase_in = xysm_pkg::PH_NONE;
                        end
                     end
                  end
                  xysm_pkg::CMD_TICK: begin
                     if (phase_ff != xysm_pkg::PH_NONE) begin
                        tick_en = 1'b1;
                        if (x_last && y_last) begin
                           if (phase_ff == xysm_pkg::PH_BACKLASH &&
                               (main_x_ff != '0 || main_y_ff != '0)) begin
                              phase_in = xysm_pkg::PH_MAIN;
                              mag_x_in = main_x_ff;
                              mag_y_in = main_y_ff;
                              state_in = xysm_pkg::ST_SQX;
                              go_in = 1'b1;
                           end else begin
                              phase_in = xysm_pkg::PH_NONE;
                           end
                        end
                     end
                  end
                  xysm_pkg::CMD_IDLE: idle = (phase_ff == xysm_pkg::PH_NONE);
                  default: ;
               endcase
            end
         end
         xysm_pkg::ST_SQX: begin
            u_start = go_ff;
            u_opa = 72'(mag_x_ff);
            u_opb = 40'(mag_x_ff);
            if (u_done) begin
               state_in = xysm_pkg::ST_SQY;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_SQY: begin
            u_start = go_ff;
            u_opa = 72'(mag_y_ff);
            u_opb = 40'(mag_y_ff);
            u_opc = 72'(s_ff);
            if (u_done) begin
               state_in = xysm_pkg::ST_PP;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_PP: begin
            u_start = go_ff;
            u_opa = 72'(min_period_ff);
            u_opb = 40'(min_period_ff);
            if (u_done) begin
               state_in = xysm_pkg::ST_PRS;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_PRS: begin
            u_start = go_ff;
            u_opa = 72'(pp_ff);
            u_opb = 40'(s_ff);
            if (u_done) begin
               state_in = xysm_pkg::ST_ROOT;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_ROOT: begin
            u_start = go_ff;
            u_op = xysm_pkg::ALU_SQRT;
            u_opa = r_ff;
            if (u_done) begin
               state_in = xysm_pkg::ST_BASE;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_BASE: begin
            u_start = go_ff;
            u_op = xysm_pkg::ALU_DIV;
            u_opa = 72'(root_ff);
            u_opb = 40'(mag_max);
            if (u_done) begin
               state_in = xysm_pkg::ST_MQ;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_MQ: begin
            u_start = go_ff;
            u_opa = 72'(q_ff);
            u_opb = 40'(mag_max);
            if (u_done) begin
               state_in = xysm_pkg::ST_DIVX;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_DIVX: begin
            u_start = go_ff;
            u_op = xysm_pkg::ALU_DIV;
            u_opa = 72'(mq_ff);
            u_opb = 40'(mag_x_ff);
            if (u_done) begin
               state_in = xysm_pkg::ST_DIVY;
               go_in = 1'b1;
            end
         end
         xysm_pkg::ST_DIVY: begin
            u_start = go_ff;
            u_op = xysm_pkg::ALU_DIV;
            u_opa = 72'(mq_ff);
            u_opb = 40'(mag_y_ff);
            if (u_done) begin
               state_in = xysm_pkg::ST_IDLE;
               axis_load = 1'b1;
            end
         end
         default: state_in = xysm_pkg::ST_IDLE;
      endcase
      rsp_in.x_step = x_step;
      rsp_in.x_motor_forward = !dir_x_in;
      rsp_in.y_step = y_step;
      rsp_in.y_motor_forward = dir_y_in;
      rsp_in.busy_res = (phase_in != xysm_pkg::PH_NONE);
      rsp_in.move_rejected = rej;
      rsp_in.motors_idle = idle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xysm_pkg::PH_NONE;
         dir_x_ff <= 1'b1;
         dir_y_ff <= 1'b1;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         main_x_ff <= '0;
         main_y_ff <= '0;
         mag_x_ff <= '0;
         mag_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
         main_x_ff <= main_x_in;
         main_y_ff <= main_y_in;
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         if (pos_take) begin
            pos_x_ff <= POSITION_BITS'(tx);
            pos_y_ff <= POSITION_BITS'(ty);
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= xysm_pkg::RESET_MIN_STEP_PERIOD;
         limit_x_ff <= xysm_pkg::RESET_LIMIT;
         limit_y_ff <= xysm_pkg::RESET_LIMIT;
         backlash_x_ff <= '0;
         backlash_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            xysm_pkg::CSR_MIN_STEP_PERIOD: min_period_ff <= csr_data;
            xysm_pkg::CSR_LIMIT_X: limit_x_ff <= csr_data[14:0];
            xysm_pkg::CSR_LIMIT_Y: limit_y_ff <= csr_data[14:0];
            xysm_pkg::CSR_BACKLASH_X: backlash_x_ff <= csr_data[7:0];
            xysm_pkg::CSR_BACKLASH_Y: backlash_y_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // capture each pass of the serial unit but the last, which loads the y axis directly
   always_ff @(posedge clock) begin
      if (u_done) begin
         case (state_ff)
            xysm_pkg::ST_SQX, xysm_pkg::ST_SQY: s_ff <= u_result[31:0];
            xysm_pkg::ST_PP: pp_ff <= u_result[39:0];
            xysm_pkg::ST_PRS: r_ff <= u_result;
            xysm_pkg::ST_ROOT: root_ff <= u_result[35:0];
            xysm_pkg::ST_BASE: q_ff <= u_result[21:0];
            xysm_pkg::ST_MQ: mq_ff <= u_result[39:0];
            xysm_pkg::ST_DIVX: per_x_ff <= per_sat;
            default: ;
         endcase
      end
   end

   xysm_serial_unit u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (u_start),
      .op     (u_op),
      .opa    (u_opa),
      .opb    (u_opb),
      .opc    (u_opc),
      .result (u_result),
      .done   (u_done)
   );

   xysm_axis #(.PERIOD_BITS(PERIOD_BITS)) u_axis_x (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick_en),
      .load        (axis_load),
      .left_load   (mag_x_ff),
      .period_load (per_x_ff),
      .step        (x_step),
      .last        (x_last)
   );

   xysm_axis #(.PERIOD_BITS(PERIOD_BITS)) u_axis_y (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick_en),
      .load        (axis_load),
      .left_load   (mag_y_ff),
      .period_load (per_sat),
      .step        (y_step),
      .last        (y_last)
   );

`include "xy_stepper_move_generator_unit_assert.svh"

   `XYSM_ASSERT_SAME(a_calc_not_ready, clock, reset, state_ff != xysm_pkg::ST_IDLE, !req_ready, "input taken during period calculation")
   `XYSM_ASSERT_SAME(a_done_in_calc, clock, reset, u_done, state_ff != xysm_pkg::ST_IDLE, "serial unit finished outside calculation")
   `XYSM_ASSERT_NEXT(a_calc_ends_idle, clock, reset, state_ff == xysm_pkg::ST_DIVY && u_done, state_ff == xysm_pkg::ST_IDLE && phase_ff != xysm_pkg::PH_NONE, "phase load did not return to idle")
   `XYSM_ASSERT_SAME(a_calc_has_phase, clock, reset, state_ff != xysm_pkg::ST_IDLE, phase_ff != xysm_pkg::PH_NONE, "calculation running without a phase")

endmodule

// ----- tb/tb_xy_stepper_move_generator_unit.sv -----
`timescale 1ns / 1ps
module tb_xy_stepper_move_generator_unit;

   typedef longint unsigned u64;
   localparam logic [39:0] PERIOD_MAX = '1;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   xysm_pkg::req_type req_data;
   xysm_pkg::rsp_type rsp_data;
   xysm_pkg::csr_index_type csr_index;
   logic [xysm_pkg::CSR_DATA_W-1:0] csr_data;

   // predicted block state and registers
   logic [19:0] cfg_period;
   logic [14:0] cfg_limit_x, cfg_limit_y;
   logic [7:0] cfg_backlash_x, cfg_backlash_y;
   logic [15:0] pos_x, pos_y, left_x, left_y;
   bit dir_x_pos, dir_y_pos;
   xysm_pkg::phase_type motion_phase;
   int delta_x, delta_y;
   logic [39:0] per_x, per_y, since_x, since_y;

   xysm_pkg::rsp_type expected_outputs[$];
   string field_name[7] = '{"x_step", "x_motor_forward", "y_step", "y_motor_forward",
                            "busy_res", "move_rejected", "motors_idle"};
   int errors, items_sent, send_idle, recv_idle, hold_left;
   longint cycles;

   xy_stepper_move_generator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [39:0] axis_period(int a, int m, u64 q);
      u64 v;
      if (a == 0) return PERIOD_MAX;
      v = u64'(m) * q / u64'(a);
      return v > PERIOD_MAX ? PERIOD_MAX : v[39:0];
   endfunction

   function automatic bit start_phase(int ax, int ay);
      int m;
      logic [127:0] area, t;
      u64 lo, hi, mid;
      m = ax > ay ? ax : ay;
      if (m == 0) return 0;
      area = 128'(cfg_period) * 128'(cfg_period) * 128'(longint'(ax) * ax + longint'(ay) * ay);
      lo = 0;
      hi = u64'(1) << 22;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 128'(mid * u64'(m));
         if (t * t <= area) lo = mid;
         else hi = mid - 1;
      end
      left_x = 16'(ax);
      left_y = 16'(ay);
      per_x = axis_period(ax, m, lo);
      per_y = axis_period(ay, m, lo);
      since_x = per_x;
      since_y = per_y;
      return 1;
   endfunction

   function automatic bit axis_tick(inout logic [15:0] left, inout logic [39:0] since,
                                    input logic [39:0] per);
      if (left == 0) return 0;
      if (since >= per) begin
         left--;
         since = 1;
         return 1;
      end
      if (since < PERIOD_MAX) since++;
      return 0;
   endfunction

   function automatic xysm_pkg::rsp_type step_outputs(xysm_pkg::req_type r);
      xysm_pkg::rsp_type o;
      int dx, dy, bx, by;
      o = '0;
      case (r.cmd)
         xysm_pkg::CMD_MOVE: begin
            if (motion_phase != xysm_pkg::PH_NONE || r.target_x == 0 ||
                r.target_x >= cfg_limit_x || r.target_y == 0 ||
                r.target_y >= cfg_limit_y) begin
               o.move_rejected = 1;
            end else begin
               dx = int'(r.target_x) - int'(pos_x);
               dy = int'(r.target_y) - int'(pos_y);
               bx = ((dx > 0 && !dir_x_pos) || (dx < 0 && dir_x_pos)) ? cfg_backlash_x : 0;
               by = ((dy > 0 && !dir_y_pos) || (dy < 0 && dir_y_pos)) ? cfg_backlash_y : 0;
               if (dx != 0) dir_x_pos = dx > 0;
               if (dy != 0) dir_y_pos = dy > 0;
               delta_x = dx;
               delta_y = dy;
               pos_x = 16'(r.target_x);
               pos_y = 16'(r.target_y);
               if (start_phase(bx, by)) motion_phase = xysm_pkg::PH_BACKLASH;
               else if (start_phase(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy))
                  motion_phase = xysm_pkg::PH_MAIN;
               else motion_phase = xysm_pkg::PH_NONE;
            end
         end
         xysm_pkg::CMD_TICK: begin
            if (motion_phase != xysm_pkg::PH_NONE) begin
               o.x_step = axis_tick(left_x, since_x, per_x);
               o.y_step = axis_tick(left_y, since_y, per_y);
               if (left_x == 0 && left_y == 0) begin
                  if (motion_phase == xysm_pkg::PH_BACKLASH &&
                      start_phase(delta_x < 0 ? -delta_x : delta_x,
                                  delta_y < 0 ? -delta_y : delta_y))
                     motion_phase = xysm_pkg::PH_MAIN;
                  else motion_phase = xysm_pkg::PH_NONE;
               end
            end
         end
         xysm_pkg::CMD_IDLE: o.motors_idle = motion_phase == xysm_pkg::PH_NONE;
         default: ;
      endcase
      o.x_motor_forward = !dir_x_pos;
      o.y_motor_forward = dir_y_pos;
      o.busy_res = motion_phase != xysm_pkg::PH_NONE;
      return o;
   endfunction

   task automatic send(xysm_pkg::cmd_type c, logic [14:0] tx, logic [14:0] ty);
      xysm_pkg::req_type r;
      r.cmd = c;
      r.target_x = tx;
      r.target_y = ty;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected_outputs.push_back(step_outputs(r));
      items_sent++;
   endtask

   task automatic run_ticks();
      while (motion_phase != xysm_pkg::PH_NONE)
         send(xysm_pkg::CMD_TICK, 15'($urandom), 15'($urandom));
   endtask

   task automatic move_to(logic [14:0] tx, logic [14:0] ty);
      send(xysm_pkg::CMD_MOVE, tx, ty);
      run_ticks();
   endtask

   task automatic csr_write(xysm_pkg::csr_index_type idx, int value);
      @(negedge clock);
      req_valid <= 0;
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (450) @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= 20'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         xysm_pkg::CSR_MIN_STEP_PERIOD: cfg_period = 20'(value);
         xysm_pkg::CSR_LIMIT_X: cfg_limit_x = 15'(value);
         xysm_pkg::CSR_LIMIT_Y: cfg_limit_y = 15'(value);
         xysm_pkg::CSR_BACKLASH_X: cfg_backlash_x = 8'(value);
         xysm_pkg::CSR_BACKLASH_Y: cfg_backlash_y = 8'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [14:0] near_target(logic [15:0] p, logic [14:0] lim);
      int v;
      v = int'(p) + int'($urandom_range(16)) - 8;
      if (v > int'(lim) - 1) v = int'(lim) - 1;
      if (v < 1) v = 1;
      return 15'(v);
   endfunction

   task automatic test_rejects_and_commands();
      csr_write(xysm_pkg::CSR_MIN_STEP_PERIOD, 0);
      send(xysm_pkg::CMD_TICK, 0, 0);
      send(xysm_pkg::CMD_MOVE, 0, 5);
      send(xysm_pkg::CMD_MOVE, 5, 0);
      send(xysm_pkg::CMD_MOVE, 1000, 5);
      send(xysm_pkg::CMD_MOVE, 5, 1000);
      send(xysm_pkg::CMD_IDLE, 0, 0);
      send(xysm_pkg::CMD_NOP, 15'h7fff, 15'h7fff);
      send(xysm_pkg::CMD_MOVE, 5, 3);
      send(xysm_pkg::CMD_MOVE, 6, 6);
      send(xysm_pkg::CMD_IDLE, 0, 0);
      run_ticks();
      send(xysm_pkg::CMD_MOVE, 5, 3);
      send(xysm_pkg::CMD_IDLE, 0, 0);
   endtask

   task automatic test_backlash();
      csr_write(xysm_pkg::CSR_BACKLASH_X, 255);
      csr_write(xysm_pkg::CSR_BACKLASH_Y, 7);
      move_to(2, 9);
      csr_write(xysm_pkg::CSR_BACKLASH_X, 3);
      move_to(4, 2);
      csr_write(xysm_pkg::CSR_BACKLASH_X, 0);
      csr_write(xysm_pkg::CSR_BACKLASH_Y, 0);
   endtask

   task automatic test_period_extremes();
      csr_write(xysm_pkg::CSR_MIN_STEP_PERIOD, 1000000);
      move_to(5, 3);
      csr_write(xysm_pkg::CSR_MIN_STEP_PERIOD, 1);
      move_to(7, 8);
      csr_write(xysm_pkg::CSR_MIN_STEP_PERIOD, 3);
      move_to(2, 5);
   endtask

   task automatic test_limit_extremes();
      csr_write(xysm_pkg::CSR_LIMIT_X, 1);
      csr_write(xysm_pkg::CSR_LIMIT_Y, 1);
      send(xysm_pkg::CMD_MOVE, 1, 1);
      csr_write(xysm_pkg::CSR_LIMIT_X, 32767);
      csr_write(xysm_pkg::CSR_LIMIT_Y, 32767);
      csr_write(xysm_pkg::CSR_MIN_STEP_PERIOD, 0);
      send(xysm_pkg::CMD_MOVE, 32767, 5);
      send(xysm_pkg::CMD_MOVE, 5, 32767);
      move_to(60, 40);
      move_to(1, 1);
   endtask

   task automatic test_output_stall();
      hold_left = 300;
      repeat (40)
         send(xysm_pkg::cmd_type'($urandom_range(3) == 0 ? xysm_pkg::CMD_IDLE :
                                                          xysm_pkg::CMD_TICK), 0, 0);
   endtask

   task automatic test_random_moves(int count);
      int stop, pick;
      repeat (2) begin
         csr_write(xysm_pkg::CSR_MIN_STEP_PERIOD, int'($urandom_range(4)));
         csr_write(xysm_pkg::CSR_LIMIT_X, int'($urandom_range(2000, 16)));
         csr_write(xysm_pkg::CSR_LIMIT_Y, int'($urandom_range(2000, 16)));
         csr_write(xysm_pkg::CSR_BACKLASH_X, int'($urandom_range(8)));
         csr_write(xysm_pkg::CSR_BACKLASH_Y, int'($urandom_range(8)));
         stop = items_sent + count / 2;
         while (items_sent < stop) begin
            if ($urandom_range(9) < 7) begin
               send(xysm_pkg::CMD_MOVE, near_target(pos_x, cfg_limit_x),
                    near_target(pos_y, cfg_limit_y));
               while (motion_phase != xysm_pkg::PH_NONE) begin
                  pick = int'($urandom_range(19));
                  if (pick == 0) send(xysm_pkg::CMD_MOVE, 15'($urandom), 15'($urandom));
                  else if (pick == 1) send(xysm_pkg::CMD_IDLE, 15'($urandom), 15'($urandom));
                  else if (pick == 2) send(xysm_pkg::CMD_NOP, 15'($urandom), 15'($urandom));
                  else send(xysm_pkg::CMD_TICK, 15'($urandom), 15'($urandom));
               end
            end else begin
               send(xysm_pkg::cmd_type'($urandom_range(3)), 15'($urandom), 15'($urandom));
            end
         end
      end
   endtask

   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 0;
            hold_left--;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      xysm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t unexpected transfer, actual %b", $time, rsp_data);
            errors++;
         end else begin
            want = expected_outputs.pop_front();
            for (int b = 6; b >= 0; b--) begin
               if (want[b] !== rsp_data[b]) begin
                  $display("%0t %s expected %0b actual %0b", $time, field_name[6 - b],
                           want[b], rsp_data[b]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = xysm_pkg::CSR_MIN_STEP_PERIOD;
      csr_data = '0;
      errors = 0;
      items_sent = 0;
      hold_left = 0;
      send_idle = 28;
      recv_idle = 62;
      cfg_period = xysm_pkg::RESET_MIN_STEP_PERIOD;
      cfg_limit_x = xysm_pkg::RESET_LIMIT;
      cfg_limit_y = xysm_pkg::RESET_LIMIT;
      cfg_backlash_x = 0;
      cfg_backlash_y = 0;
      pos_x = 0;
      pos_y = 0;
      left_x = 0;
      left_y = 0;
      dir_x_pos = 1;
      dir_y_pos = 1;
      motion_phase = xysm_pkg::PH_NONE;
      delta_x = 0;
      delta_y = 0;
      per_x = 0;
      per_y = 0;
      since_x = 0;
      since_y = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_rejects_and_commands();
      test_backlash();
      test_period_extremes();
      test_limit_extremes();
      test_output_stall();
      test_random_moves(100);
      send_idle = 62;
      recv_idle = 28;
      test_random_moves(100);
      send_idle = 0;
      recv_idle = 0;
      test_random_moves(100);
      @(negedge clock);
      req_valid <= 0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (450) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
